FILE: sv/pinhole_ray_generation_unit_defines.svh
// Assertion helpers for the ray generation unit RTL.
`ifndef PINHOLE_RAY_GENERATION_UNIT_DEFINES_SVH
`define PINHOLE_RAY_GENERATION_UNIT_DEFINES_SVH

// Check a property while out of reset.
`define PRGU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included.
`define PRGU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/prgu_pkg.sv
package prgu_pkg;

  // Signed width of a camera-space component in Q.8 pixel units.
  localparam int unsigned AW = 26;
  // Width of the sum of squares.
  localparam int unsigned SW = 50;
  // Width of the integer square root.
  localparam int unsigned RW = 25;
  // Fraction bits of the rotation entries.
  localparam int unsigned ROT_FRAC = 14;
  localparam int unsigned DIR_W = 16;
  localparam int unsigned CFG_W = 48;
  localparam int unsigned PIX_W = 13;
  localparam int unsigned FOCAL_W = 24;
  localparam int unsigned PDATA_W = 64;
  localparam int unsigned PADDR_W = 6;

  typedef enum logic [2:0] {
    REG_ROT_ROW0     = 3'd0,
    REG_ROT_ROW1     = 3'd1,
    REG_ROT_ROW2     = 3'd2,
    REG_CAM_POSITION = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5,
    REG_FOCAL_LENGTH = 3'd6
  } reg_idx_e;

  typedef logic [2:0][AW-1:0] avec_t;

endpackage

FILE: sv/prgu_isqrt.sv
module prgu_isqrt #(
  parameter int unsigned TAG_W = 78
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [prgu_pkg::SW-1:0]   s_i,
  input  logic [TAG_W-1:0]          tag_i,
  output logic                      valid_o,
  output logic [prgu_pkg::RW-1:0]   root_o,
  output logic [TAG_W-1:0]          tag_o
);
  import prgu_pkg::*;

  logic [SW-1:0]    rem_q  [RW];
  logic [RW-1:0]    root_q [RW];
  logic [TAG_W-1:0] tag_q  [RW];
  logic [RW-1:0]    vld_q;

  // One root bit per stage, most significant first.
  for (genvar i = 0; i < RW; i++) begin : g_step
    localparam int unsigned B = RW - 1 - i;
    logic [SW-1:0]    rem_in;
    logic [RW-1:0]    root_in;
    logic [TAG_W-1:0] tag_in;
    logic             vld_in;
    logic [SW+1:0]    trial;
    logic             take;

    if (i == 0) begin : g_first
      assign rem_in  = s_i;
      assign root_in = '0;
      assign tag_in  = tag_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign tag_in  = tag_q[i-1];
      assign vld_in  = vld_q[i-1];
    end

    assign trial = ((SW+2)'(root_in) << (B + 1)) + ((SW+2)'(1) << (2 * B));
    assign take  = {2'b00, rem_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= take ? rem_in - trial[SW-1:0] : rem_in;
        root_q[i] <= take ? (root_in | (RW'(1) << B)) : root_in;
        tag_q[i]  <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign tag_o   = tag_q[RW-1];

endmodule

FILE: sv/prgu_div.sv
module prgu_div #(
  parameter int unsigned DIR_FRAC_BITS = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [prgu_pkg::AW-1:0]     a_i,
  input  logic [prgu_pkg::RW-1:0]     root_i,
  output logic                        valid_o,
  output logic [DIR_FRAC_BITS+1:0]    n_o
);
  import prgu_pkg::*;

  localparam int unsigned QB = DIR_FRAC_BITS + 1;
  localparam int unsigned NW = AW + DIR_FRAC_BITS + 1;
  localparam int unsigned DW = RW + 1;
  localparam int unsigned OW = DIR_FRAC_BITS + 2;

  logic [AW-1:0] a_neg;
  logic [AW-2:0] mag;

  logic [NW-1:0] rem_q [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic [DW-1:0] den_q [QB+1];
  logic          neg_q [QB+1];
  logic [QB:0]   vld_q;
  logic [OW-1:0] n_q;
  logic          nvld_q;

  assign a_neg = AW'(0) - a_i;
  assign mag   = a_i[AW-1] ? a_neg[AW-2:0] : a_i[AW-2:0];

  // Form 2*|a|*2^D + r over 2*r so the floor gives the rounded quotient.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= (NW'(mag) << QB) + NW'(root_i);
      quo_q[0] <= '0;
      den_q[0] <= {root_i, 1'b0};
      neg_q[0] <= a_i[AW-1];
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_step
    localparam int unsigned B = QB - j;
    logic [NW-1:0] trial;
    logic          take;

    assign trial = NW'(den_q[j-1]) << B;
    assign take  = rem_q[j-1] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= take ? rem_q[j-1] - trial : rem_q[j-1];
        quo_q[j] <= take ? (quo_q[j-1] | (QB'(1) << B)) : quo_q[j-1];
        den_q[j] <= den_q[j-1];
        neg_q[j] <= neg_q[j-1];
      end
    end
  end

  // Restore the sign.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nvld_q <= 1'b0;
    end else if (en_i) begin
      nvld_q <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= neg_q[QB] ? OW'(0) - OW'(quo_q[QB]) : OW'(quo_q[QB]);
    end
  end

  assign valid_o = nvld_q;
  assign n_o     = n_q;

endmodule

FILE: sv/pinhole_ray_generation_unit.sv
// Channel   Direction  Handshake                  Payload
// pixel     in         in_valid_i / in_stall_o    pixel_u_i, pixel_v_i
// ray       out        out_valid_o / out_stall_i  dir_x/y/z_o, origin_x/y/z_o
// config    in         psel/penable/pwrite        paddr, pwdata, prdata
//
// One ray per cycle while no finished ray is stalled at the output; the pipeline is
// built around the 25-stage square root and the DIR_FRAC_BITS + 1 stage divider lanes.
// The whole pipeline advances together and holds while a finished ray is stalled.
// Reset clears all valid bits and loads the default camera registers.
module pinhole_ray_generation_unit #(
  parameter int unsigned COORD_BITS    = 12,
  parameter int unsigned DIR_FRAC_BITS = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [COORD_BITS-1:0]             pixel_u_i,
  input  logic [COORD_BITS-1:0]             pixel_v_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [prgu_pkg::DIR_W-1:0] dir_x_o,
  output logic signed [prgu_pkg::DIR_W-1:0] dir_y_o,
  output logic signed [prgu_pkg::DIR_W-1:0] dir_z_o,
  output logic signed [prgu_pkg::DIR_W-1:0] origin_x_o,
  output logic signed [prgu_pkg::DIR_W-1:0] origin_y_o,
  output logic signed [prgu_pkg::DIR_W-1:0] origin_z_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [prgu_pkg::PADDR_W-1:0]      paddr,
  input  logic [prgu_pkg::PDATA_W-1:0]      pwdata,
  output logic [prgu_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);
  import prgu_pkg::*;
  `include "pinhole_ray_generation_unit_defines.svh"

  localparam int unsigned OW = DIR_FRAC_BITS + 2;
  localparam int unsigned PW = DIR_W + OW;
  localparam int unsigned XW = PW + 2;

  // Configuration registers.
  logic [CFG_W-1:0]   rot_q [3];
  logic [CFG_W-1:0]   pos_q;
  logic [PIX_W-1:0]   width_q;
  logic [PIX_W-1:0]   height_q;
  logic [FOCAL_W-1:0] focal_q;
  reg_idx_e           idx;
  logic               wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[5:3]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= CFG_W'(48'h0000_0000_4000);
      rot_q[1] <= CFG_W'(48'h0000_4000_0000);
      rot_q[2] <= CFG_W'(48'h4000_0000_0000);
      pos_q    <= '0;
      width_q  <= PIX_W'(400);
      height_q <= PIX_W'(400);
      focal_q  <= FOCAL_W'(142222);
    end else if (wr) begin
      unique case (idx)
        REG_ROT_ROW0:     rot_q[0] <= pwdata[CFG_W-1:0];
        REG_ROT_ROW1:     rot_q[1] <= pwdata[CFG_W-1:0];
        REG_ROT_ROW2:     rot_q[2] <= pwdata[CFG_W-1:0];
        REG_CAM_POSITION: pos_q    <= pwdata[CFG_W-1:0];
        REG_IMAGE_WIDTH:  width_q  <= pwdata[PIX_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= pwdata[PIX_W-1:0];
        REG_FOCAL_LENGTH: focal_q  <= pwdata[FOCAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROT_ROW0:     prdata = PDATA_W'(rot_q[0]);
      REG_ROT_ROW1:     prdata = PDATA_W'(rot_q[1]);
      REG_ROT_ROW2:     prdata = PDATA_W'(rot_q[2]);
      REG_CAM_POSITION: prdata = PDATA_W'(pos_q);
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(width_q);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(height_q);
      REG_FOCAL_LENGTH: prdata = PDATA_W'(focal_q);
      default:          prdata = '0;
    endcase
  end

  // Global advance: hold everything while the output transaction is stalled.
  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Stage A: camera-space vector.
  logic [FOCAL_W-1:0] f_eff;
  logic [AW-1:0]      u_ext, v_ext;
  avec_t              a_d, a_q;
  logic               vld_a_q;

  assign f_eff  = (focal_q == '0) ? FOCAL_W'(1) : focal_q;
  assign u_ext  = AW'(pixel_u_i);
  assign v_ext  = AW'(pixel_v_i);
  assign a_d[0] = ((u_ext << 1) - AW'(width_q)) << 7;
  assign a_d[1] = (AW'(height_q) - (v_ext << 1)) << 7;
  assign a_d[2] = AW'(0) - AW'(f_eff);

  // Stage B: squares. Stage C: sum of squares.
  logic [SW-1:0] sq_q [3];
  avec_t         a_b_q, a_c_q;
  logic [SW-1:0] s_q;
  logic          vld_b_q, vld_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else if (en) begin
      vld_a_q <= in_valid_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q   <= a_d;
      a_b_q <= a_q;
      a_c_q <= a_b_q;
      s_q   <= sq_q[0] + sq_q[1] + sq_q[2];
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= SW'($signed(a_q[k]) * $signed(a_q[k]));
      end
    end
  end

  // Square root, vector rides along as a tag.
  logic          root_vld;
  logic [RW-1:0] root;
  avec_t         a_r;

  prgu_isqrt #(
    .TAG_W ($bits(avec_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_c_q),
    .s_i     (s_q),
    .tag_i   (a_c_q),
    .valid_o (root_vld),
    .root_o  (root),
    .tag_o   (a_r)
  );

  // Normalize, one divider lane per component.
  logic [2:0]    n_vld;
  logic [OW-1:0] n [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    prgu_div #(
      .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (root_vld),
      .a_i     (a_r[k]),
      .root_i  (root),
      .valid_o (n_vld[k]),
      .n_o     (n[k])
    );
  end

  // Rotate: products, row sums, then round and saturate.
  logic signed [PW-1:0] prod_q [3][3];
  logic signed [XW-1:0] acc_q [3];
  logic signed [DIR_W-1:0] dir_q [3];
  logic [XW-1:0] mag [3];
  logic [XW-1:0] quo [3];
  logic signed [XW-1:0] rnd [3];
  logic signed [DIR_W-1:0] dir_d [3];
  logic vld_p_q, vld_s_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag[j] = acc_q[j][XW-1] ? XW'(0) - XW'(acc_q[j]) : XW'(acc_q[j]);
      quo[j] = (mag[j] + (XW'(1) << (ROT_FRAC - 1))) >> ROT_FRAC;
      rnd[j] = acc_q[j][XW-1] ? $signed(XW'(0) - quo[j]) : $signed(quo[j]);
      priority if (rnd[j] > $signed(XW'(32767))) begin
        dir_d[j] = DIR_W'(16'sh7FFF);
      end else if (rnd[j] < -$signed(XW'(32768))) begin
        dir_d[j] = DIR_W'(16'sh8000);
      end else begin
        dir_d[j] = rnd[j][DIR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_p_q     <= 1'b0;
      vld_s_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_p_q     <= n_vld[0];
      vld_s_q     <= vld_p_q;
      out_valid_q <= vld_s_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[j][k] <= PW'($signed(rot_q[j][16*k +: 16]) * $signed(n[k]));
        end
        acc_q[j] <= XW'(prod_q[j][0]) + XW'(prod_q[j][1]) + XW'(prod_q[j][2]);
        dir_q[j] <= dir_d[j];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign dir_x_o     = dir_q[0];
  assign dir_y_o     = dir_q[1];
  assign dir_z_o     = dir_q[2];
  assign origin_x_o  = pos_q[15:0];
  assign origin_y_o  = pos_q[31:16];
  assign origin_z_o  = pos_q[47:32];

  `PRGU_ASSERT(a_lanes_aligned, (n_vld[0] == n_vld[1]) && (n_vld[0] == n_vld[2]), "divider lanes out of step")
  `PRGU_ASSERT(a_root_nonzero, root_vld |-> (root != '0), "zero root reached the divider")
  `PRGU_ASSERT(a_accept_enters, (in_valid_i && !in_stall_o) |=> vld_a_q, "accepted pixel did not enter the pipeline")
  `PRGU_ASSERT(a_unit_bound, n_vld[0] |-> (($signed(n[0]) <= $signed(OW'(1) << DIR_FRAC_BITS)) && ($signed(n[0]) >= -$signed(OW'(1) << DIR_FRAC_BITS))), "normalized component exceeds one")

endmodule
